@@ rtl/core/ccfd_pkg.sv @@
// Shared constants and types for the cassette cycle frame decoder.
package ccfd_pkg;

    localparam int unsigned BLOCK_BYTES_MAX = 131072;
    localparam int unsigned BLOCK_BYTES_W   = $clog2(BLOCK_BYTES_MAX + 1);

    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CLASS_W    = 2;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned TONE_W     = 32;
    localparam int unsigned DELAY_W    = 32;
    localparam int unsigned PIDX_W     = 5;
    localparam int unsigned BIT_IDX_W  = 4;
    localparam int unsigned BYTE_BITS  = 8;

    localparam logic [LEN_W-1:0] MAX_CYCLE_RESET = 16'd2000;

    // Dummy byte: three short, two long, then short-short-long four times.
    localparam int unsigned PATTERN_LEN = 17;
    localparam logic [PATTERN_LEN-1:0] DUMMY_PATTERN = 17'b1_0010_0100_1001_1000;
    localparam logic [PIDX_W-1:0] PATTERN_RESUME = 5'd3;

    localparam logic [TONE_W-1:0] HSTART_TONE_MIN = 32'd1;
    localparam logic [TONE_W-1:0] HEADER_TONE_MIN = 32'd7;
    localparam logic [TONE_W-1:0] DUMMY_TONE_MIN  = 32'd8;

    typedef enum logic [CLASS_W-1:0] {
        CLS_SHORT   = 2'd0,
        CLS_LONG    = 2'd1,
        CLS_INVALID = 2'd2,
        CLS_OTHER   = 2'd3
    } cycle_class_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PAUSE  = 3'd0,
        EV_HEADER = 3'd1,
        EV_DUMMY  = 3'd2,
        EV_BYTE   = 3'd3,
        EV_END    = 3'd4
    } event_kind_t;

    function automatic logic pattern_bit(input logic [PIDX_W-1:0] idx);
        logic r;
        r = 1'b0;
        for (int i = 0; i < PATTERN_LEN; i++) begin
            if (idx == PIDX_W'(i)) begin
                r = DUMMY_PATTERN[i];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cassette_cycle_frame_decoder.sv @@
// Cassette tape cycle classifier back end: frames cycles into tone, byte and block events.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | tdata: cycle_length, tuser: cycle_class
//  m_      | out       | m_tvalid / m_tready    | tdata: event_value, tuser: event_kind
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_data: max_cycle_length
//
// One beat per clock while the result register is not stalled: a beat waits in the input
// register; the state registers and the result register update at the edge that takes it.
// Reset (aresetn low, synchronous) clears the machine; no clearing pass.
// A stalled result register holds the input register, which then holds s_tready low.
module cassette_cycle_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cycle_length
    input  logic [1:0]  s_tuser,   // [1:0] cycle_class
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] event_value
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_NOSIG   = 3'd0,
        PH_HSTART  = 3'd1,
        PH_DUMMY   = 3'd2,
        PH_HEADER  = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DATA    = 3'd5,
        PH_START   = 3'd6,
        PH_STOP    = 3'd7
    } phase_t;

    localparam logic [ccfd_pkg::TONE_W-1:0] TONE_SAT = '1;
    localparam logic [ccfd_pkg::BLOCK_BYTES_W-1:0] BB_MAX =
        ccfd_pkg::BLOCK_BYTES_W'(ccfd_pkg::BLOCK_BYTES_MAX);

    logic [ccfd_pkg::LEN_W-1:0]   max_len_reg;
    logic                         in_valid_reg;
    logic [ccfd_pkg::LEN_W-1:0]   in_len_reg;
    logic [ccfd_pkg::CLASS_W-1:0] in_cls_reg;

    phase_t                          phase_reg, phase_next;
    logic [ccfd_pkg::TONE_W-1:0]     tone_reg, tone_next;
    logic                            tone_neg_reg, tone_neg_next;
    logic [ccfd_pkg::PIDX_W-1:0]     pidx_reg, pidx_next;
    logic [ccfd_pkg::DELAY_W-1:0]    delay_reg, delay_next;
    logic [ccfd_pkg::BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic                            half_reg, half_next;
    logic [ccfd_pkg::BYTE_BITS-1:0]  shift_reg, shift_next;
    logic [ccfd_pkg::BLOCK_BYTES_W-1:0] bb_reg, bb_next;

    logic                          out_valid_reg;
    logic [ccfd_pkg::KIND_W-1:0]   out_kind_reg;
    logic [ccfd_pkg::VALUE_W-1:0]  out_value_reg;

    logic                          fire;
    logic                          emit;
    ccfd_pkg::event_kind_t         ev_kind;
    logic [ccfd_pkg::VALUE_W-1:0]  ev_value;

    logic                          is_short, is_long;
    logic [ccfd_pkg::TONE_W-1:0]   tone_inc;
    logic [ccfd_pkg::DELAY_W:0]    delay_sum;
    logic [ccfd_pkg::DELAY_W-1:0]  delay_sat;
    logic [ccfd_pkg::VALUE_W-1:0]  tone_out;
    logic                          match;
    logic                          half_flip;
    logic [ccfd_pkg::BYTE_BITS-1:0] bit_mask;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_value_reg;
    assign m_tuser   = out_kind_reg;

    assign is_short = (in_cls_reg == ccfd_pkg::CLS_SHORT);
    assign is_long  = (in_cls_reg == ccfd_pkg::CLS_LONG);

    // A negative count only exists right after reset; the next increment lands on zero.
    assign tone_inc  = tone_neg_reg ? '0 : ((tone_reg == TONE_SAT) ? tone_reg : tone_reg + 1'b1);
    assign tone_out  = tone_neg_reg ? '1 : tone_reg;
    assign delay_sum = {1'b0, delay_reg} + (ccfd_pkg::DELAY_W + 1)'(in_len_reg);
    assign delay_sat = delay_sum[ccfd_pkg::DELAY_W] ? '1 : delay_sum[ccfd_pkg::DELAY_W-1:0];
    assign match     = (pidx_reg < ccfd_pkg::PIDX_W'(ccfd_pkg::PATTERN_LEN)) &&
                       ((is_short && !ccfd_pkg::pattern_bit(pidx_reg)) ||
                        (is_long && ccfd_pkg::pattern_bit(pidx_reg)));
    assign half_flip = ~half_reg;
    assign bit_mask  = ccfd_pkg::BYTE_BITS'(1) << bit_idx_reg[2:0];

    always_comb begin
        phase_next    = phase_reg;
        tone_next     = tone_reg;
        tone_neg_next = tone_neg_reg;
        pidx_next     = pidx_reg;
        delay_next    = delay_reg;
        bit_idx_next  = bit_idx_reg;
        half_next     = half_reg;
        shift_next    = shift_reg;
        bb_next       = bb_reg;
        emit          = 1'b0;
        ev_kind       = ccfd_pkg::EV_PAUSE;
        ev_value      = '0;

        case (phase_reg)
            PH_NOSIG: begin
                delay_next = delay_sat;
                if (is_short) begin
                    tone_next     = tone_inc;
                    tone_neg_next = 1'b0;
                    if (tone_inc > ccfd_pkg::HSTART_TONE_MIN) begin
                        phase_next = PH_HSTART;
                        pidx_next  = ccfd_pkg::PATTERN_RESUME;
                    end
                end else begin
                    tone_next     = '0;
                    tone_neg_next = 1'b0;
                    pidx_next     = '0;
                end
            end
            PH_HSTART: begin
                if (match || is_short) begin
                    if (match) begin
                        pidx_next = pidx_reg + 1'b1;
                        if (!is_short) begin
                            tone_next     = '0;
                            tone_neg_next = 1'b0;
                        end
                    end else begin
                        tone_next     = tone_inc;
                        tone_neg_next = 1'b0;
                        pidx_next     = '0;
                    end
                    if (pidx_next >= ccfd_pkg::PIDX_W'(ccfd_pkg::PATTERN_LEN)) begin
                        phase_next = PH_DUMMY;
                        emit       = 1'b1;
                        ev_kind    = ccfd_pkg::EV_PAUSE;
                        ev_value   = delay_reg;
                        delay_next = '0;
                    end else if (!tone_neg_next && tone_next > ccfd_pkg::HEADER_TONE_MIN) begin
                        phase_next = PH_HEADER;
                        emit       = 1'b1;
                        ev_kind    = ccfd_pkg::EV_PAUSE;
                        ev_value   = delay_reg;
                        delay_next = '0;
                    end
                end else begin
                    phase_next = PH_NOSIG;
                end
            end
            PH_DUMMY, PH_HEADER: begin
                if (is_short) begin
                    tone_next     = tone_inc;
                    tone_neg_next = 1'b0;
                end else if (phase_reg == PH_DUMMY && is_long &&
                             (tone_neg_reg || tone_reg < ccfd_pkg::DUMMY_TONE_MIN)) begin
                    tone_next     = '0;
                    tone_neg_next = 1'b0;
                end else begin
                    emit          = 1'b1;
                    ev_kind       = (phase_reg == PH_DUMMY) ? ccfd_pkg::EV_DUMMY
                                                            : ccfd_pkg::EV_HEADER;
                    ev_value      = tone_out;
                    phase_next    = is_long ? PH_DATA : PH_NOSIG;
                    tone_next     = '0;
                    tone_neg_next = 1'b0;
                    bit_idx_next  = '0;
                    half_next     = 1'b0;
                end
            end
            PH_DATA: begin
                if (is_short) begin
                    half_next = half_flip;
                    if (!half_flip) begin
                        shift_next   = shift_reg | bit_mask;
                        bit_idx_next = bit_idx_reg + 1'b1;
                    end
                end else begin
                    half_next    = 1'b0;
                    bit_idx_next = bit_idx_reg + 1'b1;
                end
                if (bit_idx_next >= ccfd_pkg::BIT_IDX_W'(ccfd_pkg::BYTE_BITS)) begin
                    emit         = 1'b1;
                    ev_kind      = ccfd_pkg::EV_BYTE;
                    ev_value     = ccfd_pkg::VALUE_W'(shift_next);
                    bb_next      = (bb_reg < BB_MAX) ? bb_reg + 1'b1 : bb_reg;
                    shift_next   = '0;
                    bit_idx_next = '0;
                    phase_next   = PH_STOP;
                end
            end
            PH_START: begin
                if (is_short) begin
                    if (bb_reg != '0) begin
                        emit          = 1'b1;
                        ev_kind       = ccfd_pkg::EV_END;
                        ev_value      = ccfd_pkg::VALUE_W'(bb_reg);
                        tone_next     = '0;
                        tone_neg_next = 1'b0;
                        phase_next    = PH_TRAILER;
                        bb_next       = '0;
                    end else begin
                        phase_next = PH_NOSIG;
                    end
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_TRAILER: begin
                if ((!is_short && !is_long) || in_len_reg > max_len_reg) begin
                    phase_next    = PH_NOSIG;
                    emit          = 1'b1;
                    ev_kind       = ccfd_pkg::EV_HEADER;
                    ev_value      = tone_out;
                    tone_next     = '0;
                    tone_neg_next = 1'b0;
                    delay_next    = '0;
                end else if (is_short) begin
                    tone_next     = tone_inc;
                    tone_neg_next = 1'b0;
                end else begin
                    emit          = 1'b1;
                    ev_kind       = ccfd_pkg::EV_HEADER;
                    ev_value      = tone_out;
                    tone_next     = '0;
                    tone_neg_next = 1'b0;
                    phase_next    = PH_DATA;
                end
            end
            PH_STOP: begin
                if (is_short) begin
                    half_next = half_flip;
                    if (!half_flip) begin
                        phase_next = PH_START;
                    end
                end else begin
                    phase_next = PH_NOSIG;
                end
            end
            default: begin
                phase_next = PH_NOSIG;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= ccfd_pkg::MAX_CYCLE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_NOSIG;
            tone_reg      <= '1;
            tone_neg_reg  <= 1'b1;
            pidx_reg      <= '0;
            delay_reg     <= '0;
            bit_idx_reg   <= '0;
            half_reg      <= 1'b0;
            shift_reg     <= '0;
            bb_reg        <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                phase_reg     <= phase_next;
                tone_reg      <= tone_next;
                tone_neg_reg  <= tone_neg_next;
                pidx_reg      <= pidx_next;
                delay_reg     <= delay_next;
                bit_idx_reg   <= bit_idx_next;
                half_reg      <= half_next;
                shift_reg     <= shift_next;
                bb_reg        <= bb_next;
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on accepted beats only.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_len_reg <= s_tdata;
            in_cls_reg <= s_tuser;
        end
        if (fire && emit) begin
            out_kind_reg  <= ev_kind;
            out_value_reg <= ev_value;
        end
    end

    a_bb_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        bb_reg <= BB_MAX)
        else $error("block byte count above limit");

    a_bit_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_idx_reg < ccfd_pkg::BIT_IDX_W'(ccfd_pkg::BYTE_BITS))
        else $error("bit index left unreset after a full byte");

    a_pidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pidx_reg <= ccfd_pkg::PIDX_W'(ccfd_pkg::PATTERN_LEN))
        else $error("pattern index past pattern end");

    a_tone_neg_nosig: assert property (@(posedge aclk) disable iff (!aresetn)
        tone_neg_reg |-> (phase_reg == PH_NOSIG))
        else $error("negative tone count outside no-signal phase");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> (!s_tready && !fire))
        else $error("input taken while result stalled");

endmodule
